// File: sv/vgm_psg_command_parser_defines.svh
// assertion macros used by the checker file
`ifndef VGM_PSG_COMMAND_PARSER_DEFINES_SVH
`define VGM_PSG_COMMAND_PARSER_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define VGMPSG_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is low
`define VGMPSG_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/vgmpsg_pkg.sv
// shared types and constants of the vgm command stream parser
package vgmpsg_pkg;

  // command opcodes
  localparam logic [7:0] OP_WRITE     = 8'hA0;
  localparam logic [7:0] OP_WAIT      = 8'h61;
  localparam logic [7:0] OP_WAIT_NTSC = 8'h62;
  localparam logic [7:0] OP_WAIT_PAL  = 8'h63;
  localparam logic [7:0] OP_END       = 8'h66;
  localparam logic [7:0] OP_SHORT_MSK = 8'hF0;
  localparam logic [7:0] OP_SHORT     = 8'h70;
  localparam logic [7:0] SHORT_N_MSK  = 8'h0F;

  // frame lengths in samples
  localparam int unsigned LEN_W     = 16;
  localparam logic [LEN_W-1:0] LEN_NTSC  = 16'd735;
  localparam logic [LEN_W-1:0] LEN_PAL   = 16'd882;
  localparam logic [LEN_W-1:0] SPF_RESET = 16'd882;

  // divider: dividend is residual plus wait, one bit more than a length
  localparam int unsigned DIV_STEPS = LEN_W + 1;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);
  localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_STEPS - 1);

  // result status codes
  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_END = 2'd1;
  localparam logic [1:0] ST_UNK = 2'd2;

  typedef enum logic [2:0] {
    PH_OPCODE,
    PH_ADDR,
    PH_DATA,
    PH_WLO,
    PH_WHI
  } phase_t;

  typedef enum logic [1:0] {
    OVR_NONE,
    OVR_735,
    OVR_882
  } ovr_t;

  typedef enum logic [2:0] {
    CS_IDLE,
    CS_DECODE,
    CS_DIVIDE,
    CS_FINISH,
    CS_DELIVER
  } ctrl_state_t;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic decode;
    logic div_step;
    logic finish;
    logic load_out;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_wait;
    logic div_last;
    logic out_free;
  } dp_stat_t;

endpackage

// File: sv/vgm_psg_command_parser.sv
// Top level of the VGM command stream parser. One command byte is taken per
// in transaction and every byte yields exactly one out transaction. A byte
// that finishes a wait (61 hi, 62, 63, 7n) passes through the 17-step
// restoring divider that splits residual plus wait into whole frames and a
// new residual; other bytes go from decode straight to delivery. A finished
// result waits in the output register, so the next byte is taken while it is
// still unread. After opcode 66 or an unknown opcode the block halts and
// answers every further byte with that status until reset. samples_per_frame
// is written through the cfg port; the user must write it only while the
// block is idle, which the block does not enforce; a value of 0 counts as 1.
module vgm_psg_command_parser (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_cmd_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_write_valid,
  output logic [7:0]  out_reg_addr,
  output logic [7:0]  out_reg_data,
  output logic [15:0] out_frames_done,
  output logic [1:0]  out_status,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_samples_per_frame
);
  import vgmpsg_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // configuration writes are always taken
  assign cfg_ready = 1'b1;

  // controller
  vgmpsg_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // datapath
  vgmpsg_dp u_dp (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cmd                   (cmd),
    .stat                  (stat),
    .in_cmd_byte           (in_cmd_byte),
    .cfg_valid             (cfg_valid),
    .cfg_samples_per_frame (cfg_samples_per_frame),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_write_valid       (out_write_valid),
    .out_reg_addr          (out_reg_addr),
    .out_reg_data          (out_reg_data),
    .out_frames_done       (out_frames_done),
    .out_status            (out_status)
  );

endmodule

// File: sv/vgmpsg_ctrl.sv
// controller state machine: sequences accept, decode, divide and delivery
module vgmpsg_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  vgmpsg_pkg::dp_stat_t stat,
  output vgmpsg_pkg::dp_cmd_t  cmd
);
  import vgmpsg_pkg::*;

  ctrl_state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= CS_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      CS_IDLE: begin
        if (in_valid) state_nxt = CS_DECODE;
      end
      CS_DECODE: begin
        state_nxt = stat.is_wait ? CS_DIVIDE : CS_DELIVER;
      end
      CS_DIVIDE: begin
        if (stat.div_last) state_nxt = CS_FINISH;
      end
      CS_FINISH: begin
        state_nxt = CS_DELIVER;
      end
      CS_DELIVER: begin
        if (stat.out_free) state_nxt = CS_IDLE;
      end
      default: begin
        state_nxt = CS_IDLE;
      end
    endcase
  end

  // outputs
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      CS_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      CS_DECODE: begin
        cmd.decode = 1'b1;
      end
      CS_DIVIDE: begin
        cmd.div_step = 1'b1;
      end
      CS_FINISH: begin
        cmd.finish = 1'b1;
      end
      CS_DELIVER: begin
        cmd.load_out = stat.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

// File: sv/vgmpsg_dp.sv
// datapath: parse state, frame residual, restoring divider and output register
module vgmpsg_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  vgmpsg_pkg::dp_cmd_t  cmd,
  output vgmpsg_pkg::dp_stat_t stat,
  input  logic [7:0]          in_cmd_byte,
  input  logic                cfg_valid,
  input  logic [15:0]         cfg_samples_per_frame,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                out_write_valid,
  output logic [7:0]          out_reg_addr,
  output logic [7:0]          out_reg_data,
  output logic [15:0]         out_frames_done,
  output logic [1:0]          out_status
);
  import vgmpsg_pkg::*;

  // parse state
  logic [7:0]       byte_r;
  phase_t           phase_r, phase_nxt;
  logic [7:0]       addr_r, addr_nxt;
  logic [7:0]       wlo_r, wlo_nxt;
  logic [LEN_W-1:0] resid_r, resid_nxt;
  ovr_t             ovr_r, ovr_nxt;
  logic             halted_r, halted_nxt;
  logic [1:0]       halt_code_r, halt_code_nxt;
  logic [LEN_W-1:0] spf_r;

  // pending result
  logic             res_wv_r, res_wv_nxt;
  logic [7:0]       res_ra_r, res_ra_nxt;
  logic [7:0]       res_rd_r, res_rd_nxt;
  logic [15:0]      res_fd_r, res_fd_nxt;
  logic [1:0]       res_st_r, res_st_nxt;

  // divider
  logic [LEN_W-1:0]     div_rem_r, div_rem_nxt;
  logic [DIV_STEPS-1:0] div_quo_r, div_quo_nxt;
  logic [LEN_W-1:0]     div_den_r, div_den_nxt;
  logic [DIV_CNT_W-1:0] div_cnt_r, div_cnt_nxt;

  // output register
  logic        out_valid_r, out_valid_nxt;
  logic        out_wv_r;
  logic [7:0]  out_ra_r, out_rd_r;
  logic [15:0] out_fd_r;
  logic [1:0]  out_st_r;

  logic             is_wait;
  logic [LEN_W-1:0] wait_n;
  logic [LEN_W-1:0] frame_len;
  logic [DIV_STEPS-1:0] div_shift;
  logic                 div_ge;

  // command decode of the latched byte
  always_comb begin
    phase_nxt     = phase_r;
    addr_nxt      = addr_r;
    wlo_nxt       = wlo_r;
    ovr_nxt       = ovr_r;
    halted_nxt    = halted_r;
    halt_code_nxt = halt_code_r;
    res_wv_nxt    = 1'b0;
    res_ra_nxt    = '0;
    res_rd_nxt    = '0;
    res_st_nxt    = ST_OK;
    is_wait       = 1'b0;
    wait_n        = '0;
    if (halted_r) begin
      res_st_nxt = halt_code_r;
    end else begin
      unique case (phase_r)
        PH_ADDR: begin
          addr_nxt  = byte_r;
          phase_nxt = PH_DATA;
        end
        PH_DATA: begin
          res_wv_nxt = 1'b1;
          res_ra_nxt = addr_r;
          res_rd_nxt = byte_r;
          phase_nxt  = PH_OPCODE;
        end
        PH_WLO: begin
          wlo_nxt   = byte_r;
          phase_nxt = PH_WHI;
        end
        PH_WHI: begin
          is_wait   = 1'b1;
          wait_n    = {byte_r, wlo_r};
          phase_nxt = PH_OPCODE;
        end
        default: begin
          phase_nxt = PH_OPCODE;
          if (byte_r == OP_WRITE) begin
            phase_nxt = PH_ADDR;
          end else if (byte_r == OP_WAIT) begin
            phase_nxt = PH_WLO;
          end else if (byte_r == OP_WAIT_NTSC) begin
            ovr_nxt = OVR_735;
            is_wait = 1'b1;
            wait_n  = LEN_NTSC;
          end else if (byte_r == OP_WAIT_PAL) begin
            ovr_nxt = OVR_882;
            is_wait = 1'b1;
            wait_n  = LEN_PAL;
          end else if (byte_r == OP_END) begin
            halted_nxt    = 1'b1;
            halt_code_nxt = ST_END;
            res_st_nxt    = ST_END;
          end else if ((byte_r & OP_SHORT_MSK) == OP_SHORT) begin
            is_wait = 1'b1;
            wait_n  = LEN_W'(byte_r & SHORT_N_MSK) + LEN_W'(1);
          end else begin
            halted_nxt    = 1'b1;
            halt_code_nxt = ST_UNK;
            res_st_nxt    = ST_UNK;
          end
        end
      endcase
    end
  end

  // frame length after this byte's override, zero treated as one
  always_comb begin
    unique case (ovr_nxt)
      OVR_735: frame_len = LEN_NTSC;
      OVR_882: frame_len = LEN_PAL;
      default: frame_len = (spf_r == '0) ? LEN_W'(1) : spf_r;
    endcase
  end

  // restoring divider, one quotient bit per step
  always_comb begin
    div_shift   = {div_rem_r, div_quo_r[DIV_STEPS-1]};
    div_ge      = (div_shift >= {1'b0, div_den_r});
    div_rem_nxt = div_rem_r;
    div_quo_nxt = div_quo_r;
    div_den_nxt = div_den_r;
    div_cnt_nxt = div_cnt_r;
    if (cmd.decode) begin
      div_rem_nxt = '0;
      div_quo_nxt = {1'b0, resid_r} + {1'b0, wait_n};
      div_den_nxt = frame_len;
      div_cnt_nxt = '0;
    end else if (cmd.div_step) begin
      div_rem_nxt = div_ge ? LEN_W'(div_shift - {1'b0, div_den_r}) : div_shift[LEN_W-1:0];
      div_quo_nxt = {div_quo_r[DIV_STEPS-2:0], div_ge};
      div_cnt_nxt = div_cnt_r + DIV_CNT_W'(1);
    end
  end

  // residual and frame count land when the divide finishes
  always_comb begin
    resid_nxt  = resid_r;
    res_fd_nxt = res_fd_r;
    if (cmd.decode) begin
      res_fd_nxt = '0;
    end else if (cmd.finish) begin
      resid_nxt  = div_rem_r;
      res_fd_nxt = div_quo_r[15:0];
    end
  end

  // output register handshake
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_OPCODE;
      addr_r      <= '0;
      wlo_r       <= '0;
      resid_r     <= '0;
      ovr_r       <= OVR_NONE;
      halted_r    <= 1'b0;
      halt_code_r <= ST_OK;
      spf_r       <= SPF_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.decode) begin
        phase_r     <= phase_nxt;
        addr_r      <= addr_nxt;
        wlo_r       <= wlo_nxt;
        ovr_r       <= ovr_nxt;
        halted_r    <= halted_nxt;
        halt_code_r <= halt_code_nxt;
      end
      resid_r <= resid_nxt;
      if (cfg_valid) begin
        spf_r <= cfg_samples_per_frame;
      end
      out_valid_r <= out_valid_nxt;
    end
  end

  // divider counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_cnt_r <= '0;
    end else begin
      div_cnt_r <= div_cnt_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      byte_r <= in_cmd_byte;
    end
    if (cmd.decode) begin
      res_wv_r <= res_wv_nxt;
      res_ra_r <= res_ra_nxt;
      res_rd_r <= res_rd_nxt;
      res_st_r <= res_st_nxt;
    end
    res_fd_r  <= res_fd_nxt;
    div_rem_r <= div_rem_nxt;
    div_quo_r <= div_quo_nxt;
    div_den_r <= div_den_nxt;
    if (cmd.load_out) begin
      out_wv_r <= res_wv_r;
      out_ra_r <= res_ra_r;
      out_rd_r <= res_rd_r;
      out_fd_r <= res_fd_r;
      out_st_r <= res_st_r;
    end
  end

  // status to the controller
  assign stat.is_wait  = is_wait;
  assign stat.div_last = (div_cnt_r == DIV_LAST);
  assign stat.out_free = !out_valid_r || out_ready;

  assign out_valid       = out_valid_r;
  assign out_write_valid = out_wv_r;
  assign out_reg_addr    = out_ra_r;
  assign out_reg_data    = out_rd_r;
  assign out_frames_done = out_fd_r;
  assign out_status      = out_st_r;

endmodule

// File: sv/vgmpsg_checker.sv
// port-level checker for the vgm command stream parser, with its bind
`include "vgm_psg_command_parser_defines.svh"

module vgmpsg_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_write_valid,
  input logic [7:0]  out_reg_addr,
  input logic [7:0]  out_reg_data,
  input logic [15:0] out_frames_done,
  input logic [1:0]  out_status
);
  import vgmpsg_pkg::*;

  // a stalled result holds its status, frame count and data
  `VGMPSG_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_status) && $stable(out_frames_done) && $stable(out_reg_data), "out payload changed while stalled")

  // a register write carries no frames and an ok status
  `VGMPSG_ASSERT_IMP(a_write_clean, clk, rst_n, out_valid && out_write_valid, out_frames_done == '0 && out_status == ST_OK, "write result with frames or bad status")

  // a halting status carries no write and no frames
  `VGMPSG_ASSERT_IMP(a_halt_clean, clk, rst_n, out_valid && out_status != ST_OK, !out_write_valid && out_frames_done == '0 && out_reg_addr == '0, "halt result with payload")

  // one byte at a time: an accepted byte closes the input for the next cycle
  `VGMPSG_ASSERT_NXT(a_one_at_a_time, clk, rst_n, in_valid && in_ready, !in_ready, "input taken on back-to-back cycles")

endmodule

bind vgm_psg_command_parser vgmpsg_checker u_checker (.*);
